// ===== hdl/h128c_pkg.sv =====
// Package for the Hamming (12,8) codec: payload types, status and request codes,
// check-bit and syndrome decode functions.
// No dependencies; compiled first.
package h128c_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int TOTAL_WIDTH = 32;
    localparam int FRAME_WIDTH = 8;
    localparam int DATA_WIDTH  = 8;
    localparam int CHECK_WIDTH = 4;
    localparam int WORD_WIDTH  = DATA_WIDTH + CHECK_WIDTH;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [TOTAL_WIDTH-1:0] total_t;
    typedef logic [FRAME_WIDTH-1:0] frame_t;
    typedef logic [DATA_WIDTH-1:0]  data_t;
    typedef logic [CHECK_WIDTH-1:0] check_t;
    typedef logic [WORD_WIDTH-1:0]  word_t;

    localparam logic REQ_ENCODE = 1'b0;
    localparam logic REQ_DECODE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAN  = 2'd0,
        ST_FIXED  = 2'd1,
        ST_UNCORR = 2'd2
    } status_t;

    // Syndrome decode: data bit to flip (0..7), no change, or uncorrectable.
    typedef logic [3:0] fix_code_t;
    localparam fix_code_t FIX_NONE = 4'd8;
    localparam fix_code_t FIX_BAD  = 4'd9;

    localparam fix_code_t SYN_MAP [16] = '{
        FIX_NONE, FIX_NONE, FIX_NONE, 4'd0,
        FIX_NONE, FIX_BAD,  4'd1,     4'd4,
        FIX_NONE, 4'd3,     FIX_BAD,  4'd5,
        4'd2,     4'd6,     4'd7,     FIX_BAD
    };

    function automatic check_t check_bits(data_t d);
        check_t c;
        c[3] = d[7] ^ d[6] ^ d[5] ^ d[3] ^ d[2];
        c[2] = d[7] ^ d[6] ^ d[4] ^ d[2] ^ d[1];
        c[1] = d[7] ^ d[5] ^ d[4] ^ d[1] ^ d[0];
        c[0] = d[6] ^ d[5] ^ d[4] ^ d[3] ^ d[0];
        return c;
    endfunction

    function automatic count_t sat_inc(count_t v);
        return (v == '1) ? v : v + count_t'(1);
    endfunction

    function automatic total_t fit_total(count_t v);
        return total_t'(v);
    endfunction

endpackage

// ===== hdl/h128c_req_if.sv =====
// Request channel of the Hamming (12,8) codec: valid/ready plus request fields.
// Depends on h128c_pkg.
interface h128c_req_if;
    logic                   valid;
    logic                   ready;
    logic                   req_type;
    h128c_pkg::data_t       data_byte;
    h128c_pkg::word_t       codeword_in;
    logic                   frame_last;

    modport source (output valid, req_type, data_byte, codeword_in, frame_last,
                    input ready);
    modport sink   (input valid, req_type, data_byte, codeword_in, frame_last,
                    output ready);
endinterface

// ===== hdl/h128c_rsp_if.sv =====
// Result channel of the Hamming (12,8) codec: valid/ready plus result fields.
// Depends on h128c_pkg.
interface h128c_rsp_if;
    logic                   valid;
    logic                   ready;
    h128c_pkg::word_t       codeword_out;
    h128c_pkg::data_t       data_out;
    logic [1:0]             status;
    h128c_pkg::total_t      clean_total;
    h128c_pkg::total_t      fixed_total;
    h128c_pkg::total_t      error_total;
    h128c_pkg::frame_t      frame_errors;

    modport source (output valid, codeword_out, data_out, status, clean_total,
                    fixed_total, error_total, frame_errors, input ready);
    modport sink   (input valid, codeword_out, data_out, status, clean_total,
                    fixed_total, error_total, frame_errors, output ready);
endinterface

// ===== hdl/hamming_12_8_codec_top.sv =====
// Hamming (12,8) codec top level: encode/decode with decode statistics.
// Pipeline: input register, then result register, with the encode/decode datapath between.
// Throughput: one request per cycle; the result register only stalls the pipe when it is
// full and the sink holds ready low.
// Reset (rst_n, async active low): clears pipe valid bits, the three saturating totals
// and the frame error count. Depends on h128c_pkg, h128c_req_if, h128c_rsp_if.
module hamming_12_8_codec_top (
    input  logic          clk,
    input  logic          rst_n,
    h128c_req_if.sink     req,
    h128c_rsp_if.source   rsp
);

    // Input register stage
    logic                   in_valid_reg;
    logic                   in_type_reg;
    h128c_pkg::data_t       in_byte_reg;
    h128c_pkg::word_t       in_word_reg;
    logic                   in_last_reg;

    // Result register stage
    logic                   out_valid_reg;
    h128c_pkg::word_t       out_word_reg;
    h128c_pkg::data_t       out_data_reg;
    h128c_pkg::status_t     out_status_reg;
    h128c_pkg::total_t      out_clean_reg;
    h128c_pkg::total_t      out_fixed_reg;
    h128c_pkg::total_t      out_error_reg;
    h128c_pkg::frame_t      out_frame_reg;

    // Running statistics
    h128c_pkg::count_t      clean_count_reg, clean_count_next;
    h128c_pkg::count_t      fixed_count_reg, fixed_count_next;
    h128c_pkg::count_t      error_count_reg, error_count_next;
    h128c_pkg::frame_t      frame_count_reg, frame_count_next;

    // Stage handshakes: the result register frees up when empty or being drained;
    // the input register advances whenever the result register can take it.
    logic                   out_free;
    logic                   advance;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign advance   = in_valid_reg && out_free;
    assign req.ready = !in_valid_reg || out_free;

    // Encode / decode datapath between the two registers
    h128c_pkg::data_t       rx_data;
    h128c_pkg::check_t      syndrome;
    h128c_pkg::fix_code_t   fix_code;
    h128c_pkg::data_t       dec_data;
    h128c_pkg::status_t     dec_status;
    h128c_pkg::frame_t      frame_report;
    h128c_pkg::word_t       res_word;
    h128c_pkg::data_t       res_data;
    h128c_pkg::status_t     res_status;

    always_comb
    begin
        rx_data    = in_word_reg[h128c_pkg::WORD_WIDTH-1:h128c_pkg::CHECK_WIDTH];
        syndrome   = h128c_pkg::check_bits(rx_data)
                     ^ in_word_reg[h128c_pkg::CHECK_WIDTH-1:0];
        fix_code   = h128c_pkg::SYN_MAP[syndrome];
        dec_data   = rx_data;
        dec_status = h128c_pkg::ST_CLEAN;
        if (fix_code == h128c_pkg::FIX_BAD)
        begin
            dec_status = h128c_pkg::ST_UNCORR;
        end
        else if (fix_code != h128c_pkg::FIX_NONE)
        begin
            // flip the single data bit the syndrome points at
            dec_data   = rx_data ^ (h128c_pkg::data_t'(1) << fix_code[2:0]);
            dec_status = h128c_pkg::ST_FIXED;
        end
    end

    // Statistics update: only decodes move counters; encodes report current counts.
    always_comb
    begin
        clean_count_next = clean_count_reg;
        fixed_count_next = fixed_count_reg;
        error_count_next = error_count_reg;
        frame_count_next = frame_count_reg;
        frame_report     = frame_count_reg;
        res_word         = {in_byte_reg, h128c_pkg::check_bits(in_byte_reg)};
        res_data         = '0;
        res_status       = h128c_pkg::ST_CLEAN;
        if (in_type_reg == h128c_pkg::REQ_DECODE)
        begin
            res_word   = '0;
            res_data   = dec_data;
            res_status = dec_status;
            case (dec_status)
                h128c_pkg::ST_UNCORR:
                begin
                    error_count_next = h128c_pkg::sat_inc(error_count_reg);
                    frame_report     = frame_count_reg + h128c_pkg::frame_t'(1);
                end
                h128c_pkg::ST_FIXED:
                begin
                    fixed_count_next = h128c_pkg::sat_inc(fixed_count_reg);
                end
                default:
                begin
                    clean_count_next = h128c_pkg::sat_inc(clean_count_reg);
                end
            endcase
            // report the frame count including this word, then drop it at frame end
            frame_count_next = in_last_reg ? '0 : frame_report;
        end
    end

    // Control state: valid bits and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            clean_count_reg <= '0;
            fixed_count_reg <= '0;
            error_count_reg <= '0;
            frame_count_reg <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                clean_count_reg <= clean_count_next;
                fixed_count_reg <= fixed_count_next;
                error_count_reg <= error_count_next;
                frame_count_reg <= frame_count_next;
            end
        end
    end

    // Payload registers: hold while stalled
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_type_reg <= req.req_type;
            in_byte_reg <= req.data_byte;
            in_word_reg <= req.codeword_in;
            in_last_reg <= req.frame_last;
        end
        if (advance)
        begin
            out_word_reg   <= res_word;
            out_data_reg   <= res_data;
            out_status_reg <= res_status;
            out_clean_reg  <= h128c_pkg::fit_total(clean_count_next);
            out_fixed_reg  <= h128c_pkg::fit_total(fixed_count_next);
            out_error_reg  <= h128c_pkg::fit_total(error_count_next);
            out_frame_reg  <= frame_report;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.codeword_out = out_word_reg;
    assign rsp.data_out     = out_data_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.clean_total  = out_clean_reg;
    assign rsp.fixed_total  = out_fixed_reg;
    assign rsp.error_total  = out_error_reg;
    assign rsp.frame_errors = out_frame_reg;

    // Totals never decrease (they saturate rather than wrap)
    a_totals_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (clean_count_reg >= $past(clean_count_reg))
              && (fixed_count_reg >= $past(fixed_count_reg))
              && (error_count_reg >= $past(error_count_reg)))
        else $error("decode total decreased");

    // An encode leaves all statistics untouched
    a_encode_keeps_stats: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_type_reg == h128c_pkg::REQ_ENCODE)
        |=> $stable(clean_count_reg) && $stable(fixed_count_reg)
            && $stable(error_count_reg) && $stable(frame_count_reg))
        else $error("encode changed statistics");

    // At most one total moves per decode
    a_one_total_moves: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> $countones({clean_count_reg != $past(clean_count_reg),
                                fixed_count_reg != $past(fixed_count_reg),
                                error_count_reg != $past(error_count_reg)}) <= 1)
        else $error("more than one total changed for one request");

    // Counters move only when a request leaves the input register
    a_stats_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(clean_count_reg) && $stable(fixed_count_reg)
                     && $stable(error_count_reg) && $stable(frame_count_reg))
        else $error("statistics changed without a request");

endmodule
